// File: rtl/btt_pkg.sv
package btt_pkg;

   // field widths of the pen and the result beat
   localparam int ANGLE_W = 16;
   localparam int POS_W   = 24;
   localparam int LEN_W   = 24;
   localparam int SINE_W  = 16;
   localparam int DEPTH_W = 6;
   localparam int SYM_W   = 8;

   // configuration register indexes
   localparam logic [2:0] REG_TURN_ANGLE = 3'd0;
   localparam logic [2:0] REG_STEP_LEN_X = 3'd1;
   localparam logic [2:0] REG_STEP_LEN_Y = 3'd2;
   localparam logic [2:0] REG_DRAW_SET_0 = 3'd3;
   localparam logic [2:0] REG_DRAW_SET_1 = 3'd4;
   localparam logic [2:0] REG_DRAW_SET_2 = 3'd5;
   localparam logic [2:0] REG_DRAW_SET_3 = 3'd6;

   // control symbols of the word
   localparam logic [SYM_W-1:0] SYM_PLUS     = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS    = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_LBRACKET = 8'h5B;
   localparam logic [SYM_W-1:0] SYM_RBRACKET = 8'h5D;

   // pen position at the start of a word: 0.5 in Q8.16
   localparam logic signed [POS_W-1:0] PEN_HALF = 24'sh008000;

   // largest and smallest signed 24-bit position
   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

   typedef enum logic [1:0] {
      KIND_SEGMENT   = 2'd0,
      KIND_POP_EMPTY = 2'd1,
      KIND_PUSH_FULL = 2'd2
   } kind_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]       heading;
      logic signed [POS_W-1:0]  pen_x;
      logic signed [POS_W-1:0]  pen_y;
   } pen_type;

endpackage

// File: rtl/btt_if.sv
interface btt_req_if import btt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             word_start;

   modport source (output valid, output symbol, output word_start, input ready);
   modport sink   (input valid, input symbol, input word_start, output ready);
endinterface

interface btt_rsp_if import btt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   kind_type                kind;
   logic signed [POS_W-1:0] start_x;
   logic signed [POS_W-1:0] start_y;
   logic signed [POS_W-1:0] delta_x;
   logic signed [POS_W-1:0] delta_y;
   logic [DEPTH_W-1:0]      nest_depth;

   modport source (output valid, output kind, output start_x, output start_y,
                   output delta_x, output delta_y, output nest_depth, input ready);
   modport sink   (input valid, input kind, input start_x, input start_y,
                   input delta_x, input delta_y, input nest_depth, output ready);
endinterface

// File: rtl/bracketed_turtle_interpreter.sv
// Turtle interpreter for bracketed L-system words.
// req_if carries one symbol beat (symbol, word_start); rsp_if carries at most
// one result beat per symbol: a line segment for a drawing symbol, or an
// error report for a pop on an empty stack or a push on a full stack.
// Both are valid/ready channels; a beat moves when valid and ready are high.
// A symbol accepted on req_if is held in the input register; its result goes
// to the result register that drives rsp_if.valid. One symbol per cycle while
// rsp_if does not stall, set by the single execute stage that updates heading,
// pen and stack in the cycle it consumes a symbol. Sine and cosine of the
// heading are kept registered next to it, so a draw costs one multiply and a
// saturating add per axis. The saved-pen stack is a memory with its top entry
// held in a register; the entry that becomes the new top is read as a symbol
// executes, so a pop never waits. When rsp_if stalls, the result register
// holds, the input register fills, and then req_if.ready drops; symbols that
// give no result still drain only in order behind the held result.
// Reset (synchronous, active high) clears heading to zero, the pen to
// (0.5, 0.5), the stack to empty and loads register reset values; stack
// memory contents are not cleared and need no clearing pass.
// csr_we writes csr_wdata to register csr_index; write only while idle.
module bracketed_turtle_interpreter import btt_pkg::*; #(
   parameter int STACK_DEPTH        = 32,
   parameter int SINE_TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   btt_req_if.sink     req_if,
   btt_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TW = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int PW = 14 + TW;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // quarter-wave sine in Q1.15 by a Taylor series in Q30
   function automatic logic [14:0] quarter_sine(input int unsigned idx);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        v;
      x    = (PI_HALF_Q30 * 64'(idx)) / 64'(SINE_TABLE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v = ((64'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

   // constant quarter-wave table
   logic [14:0] sine_rom [SINE_TABLE_ENTRIES+1];

   for (genvar i = 0; i <= SINE_TABLE_ENTRIES; i++) begin : g_rom
      assign sine_rom[i] = quarter_sine(i);
   end

   // full-turn sine from the quarter table
   function automatic logic signed [SINE_W-1:0] sine_of(input logic [ANGLE_W-1:0] h);
      logic [PW-1:0]     prod;
      logic [TW-1:0]     f;
      logic [TW-1:0]     idx;
      logic [SINE_W-1:0] v;
      prod = PW'(h[13:0]) * PW'(SINE_TABLE_ENTRIES);
      f    = TW'(prod >> 14);
      idx  = h[14] ? TW'(SINE_TABLE_ENTRIES) - f : f;
      v    = {1'b0, sine_rom[idx]};
      return h[15] ? signed'(SINE_W'(-v)) : signed'(v);
   endfunction

   // configuration registers
   logic [ANGLE_W-1:0] turn_ff;
   logic [LEN_W-1:0]   step_x_ff;
   logic [LEN_W-1:0]   step_y_ff;
   logic [63:0]        draw_set_ff [4];

   // pen state
   logic [ANGLE_W-1:0]       heading_ff, heading_in;
   logic signed [SINE_W-1:0] sin_ff, sin_in;
   logic signed [SINE_W-1:0] cos_ff, cos_in;
   logic signed [POS_W-1:0]  pen_x_ff, pen_x_in;
   logic signed [POS_W-1:0]  pen_y_ff, pen_y_in;
   logic [CW-1:0]            count_ff, count_in;

   // saved pens: memory plus registered top entry
   pen_type       stack_mem [STACK_DEPTH];
   pen_type       top_ff;
   pen_type       push_entry;
   logic          push;
   logic [AW-1:0] rd_addr;

   // input register
   logic             in_valid_ff;
   logic [SYM_W-1:0] in_symbol_ff;
   logic             in_start_ff;

   // result register
   logic                    out_valid_ff;
   kind_type                out_kind_ff;
   logic signed [POS_W-1:0] out_sx_ff;
   logic signed [POS_W-1:0] out_sy_ff;
   logic signed [POS_W-1:0] out_dx_ff;
   logic signed [POS_W-1:0] out_dy_ff;
   logic [DEPTH_W-1:0]      out_depth_ff;

   // execute stage signals
   logic                     exec_go;
   logic [ANGLE_W-1:0]       eff_heading;
   logic signed [SINE_W-1:0] eff_sin;
   logic signed [SINE_W-1:0] eff_cos;
   logic signed [POS_W-1:0]  eff_x;
   logic signed [POS_W-1:0]  eff_y;
   logic [CW-1:0]            eff_count;
   logic                     emit;
   kind_type                 emit_kind;
   logic signed [POS_W-1:0]  emit_dx;
   logic signed [POS_W-1:0]  emit_dy;
   logic signed [POS_W-1:0]  step_dx;
   logic signed [POS_W-1:0]  step_dy;
   logic signed [POS_W:0]    sum_x;
   logic signed [POS_W:0]    sum_y;

   // handshakes
   assign exec_go       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || exec_go;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff     <= '0;
         step_x_ff   <= LEN_W'(65536);
         step_y_ff   <= LEN_W'(65536);
         draw_set_ff <= '{default: '0};
      end else if (csr_we) begin
         case (csr_index)
            REG_TURN_ANGLE: turn_ff        <= csr_wdata[ANGLE_W-1:0];
            REG_STEP_LEN_X: step_x_ff      <= csr_wdata[LEN_W-1:0];
            REG_STEP_LEN_Y: step_y_ff      <= csr_wdata[LEN_W-1:0];
            REG_DRAW_SET_0: draw_set_ff[0] <= csr_wdata;
            REG_DRAW_SET_1: draw_set_ff[1] <= csr_wdata;
            REG_DRAW_SET_2: draw_set_ff[2] <= csr_wdata;
            REG_DRAW_SET_3: draw_set_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // capture the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         in_valid_ff <= 1'b1;
      end else if (exec_go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_symbol_ff <= req_if.symbol;
         in_start_ff  <= req_if.word_start;
      end
   end

   // pen as seen by this symbol, after an optional word start
   always_comb begin
      eff_heading = in_start_ff ? '0 : heading_ff;
      eff_sin     = in_start_ff ? signed'({1'b0, sine_rom[0]}) : sin_ff;
      eff_cos     = in_start_ff ? signed'({1'b0, sine_rom[SINE_TABLE_ENTRIES]}) : cos_ff;
      eff_x       = in_start_ff ? PEN_HALF : pen_x_ff;
      eff_y       = in_start_ff ? PEN_HALF : pen_y_ff;
      eff_count   = in_start_ff ? '0 : count_ff;
   end

   // segment steps along x and y
   btt_scale u_scale_x (
      .sine     (eff_sin),
      .step_len (step_x_ff),
      .delta    (step_dx)
   );

   btt_scale u_scale_y (
      .sine     (eff_cos),
      .step_len (step_y_ff),
      .delta    (step_dy)
   );

   // decode the symbol and form the next pen state
   always_comb begin
      heading_in = eff_heading;
      pen_x_in   = eff_x;
      pen_y_in   = eff_y;
      count_in   = eff_count;
      push       = 1'b0;
      emit       = 1'b0;
      emit_kind  = KIND_SEGMENT;
      emit_dx    = '0;
      emit_dy    = '0;
      sum_x      = (POS_W+1)'(eff_x) + (POS_W+1)'(step_dx);
      sum_y      = (POS_W+1)'(eff_y) + (POS_W+1)'(step_dy);
      push_entry = '{heading: eff_heading, pen_x: eff_x, pen_y: eff_y};
      case (in_symbol_ff)
         SYM_PLUS: begin
            heading_in = eff_heading + turn_ff;
         end
         SYM_MINUS: begin
            heading_in = eff_heading - turn_ff;
         end
         SYM_LBRACKET: begin
            if (32'(eff_count) >= 32'(STACK_DEPTH)) begin
               emit      = 1'b1;
               emit_kind = KIND_PUSH_FULL;
            end else begin
               push     = 1'b1;
               count_in = eff_count + CW'(1);
            end
         end
         SYM_RBRACKET: begin
            if (eff_count == '0) begin
               emit      = 1'b1;
               emit_kind = KIND_POP_EMPTY;
            end else begin
               count_in   = eff_count - CW'(1);
               heading_in = top_ff.heading;
               pen_x_in   = top_ff.pen_x;
               pen_y_in   = top_ff.pen_y;
            end
         end
         default: begin
            if (draw_set_ff[in_symbol_ff[7:6]][in_symbol_ff[5:0]]) begin
               emit    = 1'b1;
               emit_dx = step_dx;
               emit_dy = step_dy;
               if (sum_x > (POS_W+1)'(POS_MAX)) begin
                  pen_x_in = POS_MAX;
               end else if (sum_x < (POS_W+1)'(POS_MIN)) begin
                  pen_x_in = POS_MIN;
               end else begin
                  pen_x_in = sum_x[POS_W-1:0];
               end
               if (sum_y > (POS_W+1)'(POS_MAX)) begin
                  pen_y_in = POS_MAX;
               end else if (sum_y < (POS_W+1)'(POS_MIN)) begin
                  pen_y_in = POS_MIN;
               end else begin
                  pen_y_in = sum_y[POS_W-1:0];
               end
            end
         end
      endcase
      sin_in = sine_of(heading_in);
      cos_in = sine_of(heading_in + ANGLE_W'(16'h4000));
   end

   // address of the entry that becomes the top after this symbol
   assign rd_addr = (count_in == '0) ? '0 : AW'(count_in - CW'(1));

   // advance the pen state
   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
         sin_ff     <= signed'({1'b0, sine_rom[0]});
         cos_ff     <= signed'({1'b0, sine_rom[SINE_TABLE_ENTRIES]});
         pen_x_ff   <= PEN_HALF;
         pen_y_ff   <= PEN_HALF;
         count_ff   <= '0;
      end else if (exec_go) begin
         heading_ff <= heading_in;
         sin_ff     <= sin_in;
         cos_ff     <= cos_in;
         pen_x_ff   <= pen_x_in;
         pen_y_ff   <= pen_y_in;
         count_ff   <= count_in;
      end
   end

   // push into the stack memory, keep the top entry registered
   always_ff @(posedge clock) begin
      if (exec_go && push) begin
         stack_mem[AW'(eff_count)] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         top_ff <= push ? push_entry : stack_mem[rd_addr];
      end
   end

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (exec_go && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && emit) begin
         out_kind_ff  <= emit_kind;
         out_sx_ff    <= eff_x;
         out_sy_ff    <= eff_y;
         out_dx_ff    <= emit_dx;
         out_dy_ff    <= emit_dy;
         out_depth_ff <= (32'(eff_count) > 32'd63) ? DEPTH_W'(63) : DEPTH_W'(eff_count);
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.kind       = out_kind_ff;
   assign rsp_if.start_x    = out_sx_ff;
   assign rsp_if.start_y    = out_sy_ff;
   assign rsp_if.delta_x    = out_dx_ff;
   assign rsp_if.delta_y    = out_dy_ff;
   assign rsp_if.nest_depth = out_depth_ff;

endmodule

// File: rtl/btt_scale.sv
module btt_scale import btt_pkg::*; (
   input  logic signed [SINE_W-1:0] sine,
   input  logic [LEN_W-1:0]         step_len,
   output logic signed [POS_W-1:0]  delta
);

   logic                      neg;
   logic [SINE_W-1:0]         mag;
   logic [SINE_W+LEN_W-1:0]   prod;
   logic [SINE_W+LEN_W-1:0]   rounded;
   logic [POS_W-1:0]          rmag;

   // scale the magnitude, round half away from zero to Q8.16
   always_comb begin
      neg     = sine[SINE_W-1];
      mag     = neg ? SINE_W'(-sine) : SINE_W'(sine);
      prod    = (SINE_W+LEN_W)'(mag) * (SINE_W+LEN_W)'(step_len);
      rounded = (prod + (SINE_W+LEN_W)'(1 << 14)) >> 15;
      rmag    = rounded[POS_W-1:0];
   end

   // restore the sign and saturate to signed 24 bits
   always_comb begin
      if (!neg) begin
         delta = (rmag > POS_W'(POS_MAX)) ? POS_MAX : signed'(rmag);
      end else begin
         delta = (rmag > POS_W'(24'h800000)) ? POS_MIN : signed'(POS_W'(-rmag));
      end
   end

endmodule
